### rtl/dnc_pkg.sv
// Shared constants, types and calendar helper functions for the day number converter.
package dnc_pkg;

  typedef logic signed [21:0] year_t;
  typedef logic [8:0] doy_t;

  localparam int DAYS_400Y = 146097;
  localparam int DAYS_100Y = 36524;
  localparam int DAYS_4Y = 1461;
  localparam int DAYS_1Y = 365;
  localparam int YEARS_CYCLE = 400;

  localparam int CYC_BIAS = 3676;
  localparam logic [30:0] DAY_OFFSET = 31'(CYC_BIAS * DAYS_400Y - 1);
  localparam logic [21:0] YEAR_BIAS = 22'(CYC_BIAS * YEARS_CYCLE);

  localparam int NUM_W = 31;
  localparam int CYCQ_W = 13;
  localparam int CYC_SHIFT = 48;
  localparam int REM400_W = 18;
  localparam int SPAN_W = 16;
  localparam int QUADQ_W = 5;
  localparam int QUAD_SHIFT = 32;
  localparam int REM4_W = 11;
  localparam int DOW_W = 3;
  localparam int SIDE_B_W = 22 + 3 + DOW_W;

  localparam logic [16:0] WEEK_RECIP = 17'd293;
  localparam int WEEK_SHIFT = 11;

  function automatic logic [2:0] iso_weekday(input logic [29:0] v);
    logic [6:0] s;
    logic [3:0] t;
    logic [3:0] w;
    s = (v[29] ? 7'd6 : 7'd0)
        + 7'(v[2:0]) + 7'(v[5:3]) + 7'(v[8:6]) + 7'(v[11:9]) + 7'(v[14:12])
        + 7'(v[17:15]) + 7'(v[20:18]) + 7'(v[23:21]) + 7'(v[26:24]) + 7'(v[29:27]);
    t = 4'(s[2:0]) + 4'(s[5:3]) + 4'(s[6]);
    w = 4'(t[2:0]) + 4'(t[3]);
    if (w >= 4'd7) begin
      w = w - 4'd7;
    end
    return (w == 4'd0) ? 3'd7 : w[2:0];
  endfunction

  function automatic logic leap400(input logic [8:0] k);
    return (k[1:0] == 2'd0) && (k != 9'd100) && (k != 9'd200) && (k != 9'd300);
  endfunction

  function automatic logic [8:0] month_start(input logic leap, input logic [3:0] m);
    logic [8:0] base;
    case (m)
      4'd2: base = 9'd31;
      4'd3: base = 9'd59;
      4'd4: base = 9'd90;
      4'd5: base = 9'd120;
      4'd6: base = 9'd151;
      4'd7: base = 9'd181;
      4'd8: base = 9'd212;
      4'd9: base = 9'd243;
      4'd10: base = 9'd273;
      4'd11: base = 9'd304;
      4'd12: base = 9'd334;
      default: base = 9'd0;
    endcase
    if (m >= 4'd3) begin
      base = base + {8'd0, leap};
    end
    return base;
  endfunction

  function automatic logic [8:0] quarter_start(input logic leap, input logic [2:0] q);
    logic [8:0] base;
    case (q)
      3'd2: base = 9'd90;
      3'd3: base = 9'd181;
      3'd4: base = 9'd273;
      default: base = 9'd0;
    endcase
    if (q >= 3'd2) begin
      base = base + {8'd0, leap};
    end
    return base;
  endfunction

endpackage

### rtl/day_number_to_calendar_fields.sv
// Top level of the day number to calendar fields converter.
//
// Channel  Dir  Data ports                                      Handshake
// in       in   in_day_number                                   in_valid, in_ready
// out      out  out_year .. out_weekday (nine result fields)    out_valid, out_ready
//
// One beat is accepted every cycle unless a stall on the output has filled the pipeline,
// since every stage can move in every cycle while out_ready is high.
// The clock rate is set by the 31 by 31 reciprocal multiply of the 400-year divider;
// every other stage holds at most one constant multiply or wide add.
// Reset clears the valid bit of each stage and nothing else.
// Each stage holds its beat until the next stage is empty or moving, so a stall on the
// output loses and repeats nothing; in_ready drops only when all twelve stages are full.
module day_number_to_calendar_fields (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [29:0] in_day_number,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [21:0] out_year,
  output logic [8:0]         out_day_of_year,
  output logic [3:0]         out_month,
  output logic [4:0]         out_day_of_month,
  output logic [2:0]         out_quarter,
  output logic [6:0]         out_day_of_quarter,
  output logic signed [21:0] out_week_year,
  output logic [5:0]         out_week,
  output logic [2:0]         out_weekday
);

  // Stage A: bias the day number to a non-negative count and find the weekday.
  logic        a_v_r;
  logic        a_rdy;
  logic [30:0] a_u_r;
  logic [2:0]  a_dow_r;
  logic [30:0] a_u_nxt;
  logic [2:0]  a_dow_nxt;

  logic        da_in_ready;
  logic        da_v;
  logic [12:0] da_q;
  logic [17:0] da_r;
  logic [2:0]  da_dow;

  logic        e_v_r;
  logic        e_rdy;
  logic [2:0]  e_n100_r;
  logic [15:0] e_r2_r;
  logic [21:0] e_yb_r;
  logic [2:0]  e_dow_r;
  logic [2:0]  e_n100_nxt;
  logic [17:0] e_sub;
  logic [15:0] e_r2_nxt;
  logic [21:0] e_yb_nxt;

  logic        db_in_ready;
  logic        db_v;
  logic [4:0]  db_q;
  logic [10:0] db_r;
  logic [27:0] db_side;

  logic        f_v_r;
  logic        f_rdy;
  logic [8:0]  f_k_r;
  logic [8:0]  f_doy_r;
  logic [21:0] f_yb_r;
  logic [2:0]  f_dow_r;
  logic [2:0]  f_n100;
  logic [2:0]  f_n1;
  logic [10:0] f_sub;
  logic [8:0]  f_r4;
  logic        f_last;
  logic [8:0]  f_k_nxt;
  logic [8:0]  f_doy_nxt;

  logic                g_v_r;
  logic                g_rdy;
  dnc_pkg::year_t      g_y_r;
  dnc_pkg::doy_t       g_doy_r;
  logic                g_l_r;
  logic                g_lp_r;
  logic [2:0]          g_dow_r;
  logic [8:0]          g_ky;
  logic [8:0]          g_kp;
  dnc_pkg::year_t      g_y_nxt;

  logic                h_v_r;
  logic                h_rdy;
  dnc_pkg::year_t      h_y_r;
  dnc_pkg::doy_t       h_doy_r;
  logic                h_l_r;
  logic [3:0]          h_m_r;
  logic [2:0]          h_q_r;
  logic [8:0]          h_wd_r;
  logic                h_dec_r;
  logic                h_inc_r;
  logic [2:0]          h_dow_r;
  logic [3:0]          h_m_nxt;
  logic [2:0]          h_q_nxt;
  logic signed [10:0]  h_wdoy;
  logic [8:0]          h_len_y;
  logic [8:0]          h_len_p;
  logic [10:0]         h_wd_wide;
  logic [8:0]          h_wd_nxt;
  logic                h_dec_nxt;
  logic                h_inc_nxt;

  logic                o_v_r;
  logic                o_rdy;
  dnc_pkg::year_t      o_year_r;
  dnc_pkg::doy_t       o_doy_r;
  logic [3:0]          o_month_r;
  logic [4:0]          o_dom_r;
  logic [2:0]          o_quarter_r;
  logic [6:0]          o_doq_r;
  dnc_pkg::year_t      o_wy_r;
  logic [5:0]          o_week_r;
  logic [2:0]          o_dow_r;
  logic [8:0]          o_dom_wide;
  logic [8:0]          o_doq_wide;
  dnc_pkg::year_t      o_wy_nxt;
  logic [16:0]         o_wprod;

  assign a_rdy = !a_v_r || da_in_ready;
  assign in_ready = a_rdy;
  assign a_u_nxt = {in_day_number[29], in_day_number} + dnc_pkg::DAY_OFFSET;
  assign a_dow_nxt = dnc_pkg::iso_weekday(in_day_number);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (a_rdy) begin
      a_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_rdy) begin
      a_u_r <= a_u_nxt;
      a_dow_r <= a_dow_nxt;
    end
  end

  dnc_cdiv #(
    .W  (dnc_pkg::NUM_W),
    .D  (dnc_pkg::DAYS_400Y),
    .S  (dnc_pkg::CYC_SHIFT),
    .QW (dnc_pkg::CYCQ_W),
    .SW (dnc_pkg::DOW_W)
  ) u_div_400y (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (a_v_r),
    .in_ready  (da_in_ready),
    .in_num    (a_u_r),
    .in_side   (a_dow_r),
    .out_valid (da_v),
    .out_ready (e_rdy),
    .out_quot  (da_q),
    .out_rem   (da_r),
    .out_side  (da_dow)
  );

  // Stage E: split the cycle remainder into centuries and form the cycle's base year.
  assign e_rdy = !e_v_r || db_in_ready;
  assign e_n100_nxt = 3'(da_r >= 18'(dnc_pkg::DAYS_100Y))
                      + 3'(da_r >= 18'(2 * dnc_pkg::DAYS_100Y))
                      + 3'(da_r >= 18'(3 * dnc_pkg::DAYS_100Y))
                      + 3'(da_r >= 18'(4 * dnc_pkg::DAYS_100Y));

  always_comb begin
    case (e_n100_nxt)
      3'd0: e_sub = 18'd0;
      3'd1: e_sub = 18'(dnc_pkg::DAYS_100Y);
      3'd2: e_sub = 18'(2 * dnc_pkg::DAYS_100Y);
      3'd3: e_sub = 18'(3 * dnc_pkg::DAYS_100Y);
      default: e_sub = 18'(4 * dnc_pkg::DAYS_100Y);
    endcase
  end

  assign e_r2_nxt = 16'(da_r - e_sub);
  assign e_yb_nxt = 22'(da_q) * 22'(dnc_pkg::YEARS_CYCLE) - dnc_pkg::YEAR_BIAS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_v_r <= 1'b0;
    end else if (e_rdy) begin
      e_v_r <= da_v;
    end
  end

  always_ff @(posedge clk) begin
    if (e_rdy) begin
      e_n100_r <= e_n100_nxt;
      e_r2_r <= e_r2_nxt;
      e_yb_r <= e_yb_nxt;
      e_dow_r <= da_dow;
    end
  end

  dnc_cdiv #(
    .W  (dnc_pkg::SPAN_W),
    .D  (dnc_pkg::DAYS_4Y),
    .S  (dnc_pkg::QUAD_SHIFT),
    .QW (dnc_pkg::QUADQ_W),
    .SW (dnc_pkg::SIDE_B_W)
  ) u_div_4y (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (e_v_r),
    .in_ready  (db_in_ready),
    .in_num    (e_r2_r),
    .in_side   ({e_yb_r, e_n100_r, e_dow_r}),
    .out_valid (db_v),
    .out_ready (f_rdy),
    .out_quot  (db_q),
    .out_rem   (db_r),
    .out_side  (db_side)
  );

  // Stage F: split the four-year remainder into years and find the day of year.
  assign f_rdy = !f_v_r || g_rdy;
  assign f_n100 = db_side[5:3];
  assign f_n1 = 3'(db_r >= 11'(dnc_pkg::DAYS_1Y))
                + 3'(db_r >= 11'(2 * dnc_pkg::DAYS_1Y))
                + 3'(db_r >= 11'(3 * dnc_pkg::DAYS_1Y))
                + 3'(db_r >= 11'(4 * dnc_pkg::DAYS_1Y));

  always_comb begin
    case (f_n1)
      3'd0: f_sub = 11'd0;
      3'd1: f_sub = 11'(dnc_pkg::DAYS_1Y);
      3'd2: f_sub = 11'(2 * dnc_pkg::DAYS_1Y);
      3'd3: f_sub = 11'(3 * dnc_pkg::DAYS_1Y);
      default: f_sub = 11'(4 * dnc_pkg::DAYS_1Y);
    endcase
  end

  assign f_r4 = 9'(db_r - f_sub);
  assign f_last = (f_n100 == 3'd4) || (f_n1 == 3'd4);
  assign f_k_nxt = 9'(f_n100) * 9'd100 + {2'b00, db_q, 2'b00} + 9'(f_n1) + {8'd0, ~f_last};
  assign f_doy_nxt = f_last ? 9'd366 : f_r4 + 9'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else if (f_rdy) begin
      f_v_r <= db_v;
    end
  end

  always_ff @(posedge clk) begin
    if (f_rdy) begin
      f_k_r <= f_k_nxt;
      f_doy_r <= f_doy_nxt;
      f_yb_r <= db_side[27:6];
      f_dow_r <= db_side[2:0];
    end
  end

  // Stage G: final year and the leap flags of this year and the one before.
  assign g_rdy = !g_v_r || h_rdy;
  assign g_ky = (f_k_r == 9'd400) ? 9'd0 : f_k_r;
  assign g_kp = (g_ky == 9'd0) ? 9'd399 : g_ky - 9'd1;
  assign g_y_nxt = f_yb_r + 22'(f_k_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_v_r <= 1'b0;
    end else if (g_rdy) begin
      g_v_r <= f_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (g_rdy) begin
      g_y_r <= g_y_nxt;
      g_doy_r <= f_doy_r;
      g_l_r <= dnc_pkg::leap400(g_ky);
      g_lp_r <= dnc_pkg::leap400(g_kp);
      g_dow_r <= f_dow_r;
    end
  end

  // Stage H: month, quarter and the day's place in the ISO week-year.
  assign h_rdy = !h_v_r || o_rdy;

  always_comb begin
    h_m_nxt = 4'd1;
    for (int i = 2; i <= 12; i++) begin
      if (g_doy_r > dnc_pkg::month_start(g_l_r, 4'(i))) begin
        h_m_nxt = h_m_nxt + 4'd1;
      end
    end
    h_q_nxt = 3'd1;
    for (int j = 2; j <= 4; j++) begin
      if (g_doy_r > dnc_pkg::quarter_start(g_l_r, 3'(j))) begin
        h_q_nxt = h_q_nxt + 3'd1;
      end
    end
  end

  assign h_wdoy = $signed({2'b00, g_doy_r}) + 11'sd4 - $signed({8'd0, g_dow_r});
  assign h_len_y = 9'd365 + {8'd0, g_l_r};
  assign h_len_p = 9'd365 + {8'd0, g_lp_r};
  assign h_dec_nxt = h_wdoy < 11'sd1;
  assign h_inc_nxt = !h_dec_nxt && (h_wdoy > $signed({2'b00, h_len_y}));

  always_comb begin
    if (h_dec_nxt) begin
      h_wd_wide = h_wdoy + {2'b00, h_len_p};
    end else if (h_inc_nxt) begin
      h_wd_wide = h_wdoy - {2'b00, h_len_y};
    end else begin
      h_wd_wide = h_wdoy;
    end
  end

  assign h_wd_nxt = h_wd_wide[8:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_v_r <= 1'b0;
    end else if (h_rdy) begin
      h_v_r <= g_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (h_rdy) begin
      h_y_r <= g_y_r;
      h_doy_r <= g_doy_r;
      h_l_r <= g_l_r;
      h_m_r <= h_m_nxt;
      h_q_r <= h_q_nxt;
      h_wd_r <= h_wd_nxt;
      h_dec_r <= h_dec_nxt;
      h_inc_r <= h_inc_nxt;
      h_dow_r <= g_dow_r;
    end
  end

  // Output stage: offsets within month and quarter, week-year and week number.
  assign o_rdy = !o_v_r || out_ready;
  assign o_dom_wide = h_doy_r - dnc_pkg::month_start(h_l_r, h_m_r);
  assign o_doq_wide = h_doy_r - dnc_pkg::quarter_start(h_l_r, h_q_r);
  assign o_wy_nxt = h_y_r - {21'd0, h_dec_r} + {21'd0, h_inc_r};
  assign o_wprod = 17'(h_wd_r + 9'd6) * dnc_pkg::WEEK_RECIP;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (o_rdy) begin
      o_v_r <= h_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (o_rdy) begin
      o_year_r <= h_y_r;
      o_doy_r <= h_doy_r;
      o_month_r <= h_m_r;
      o_dom_r <= o_dom_wide[4:0];
      o_quarter_r <= h_q_r;
      o_doq_r <= o_doq_wide[6:0];
      o_wy_r <= o_wy_nxt;
      o_week_r <= o_wprod[dnc_pkg::WEEK_SHIFT +: 6];
      o_dow_r <= h_dow_r;
    end
  end

  assign out_valid = o_v_r;
  assign out_year = o_year_r;
  assign out_day_of_year = o_doy_r;
  assign out_month = o_month_r;
  assign out_day_of_month = o_dom_r;
  assign out_quarter = o_quarter_r;
  assign out_day_of_quarter = o_doq_r;
  assign out_week_year = o_wy_r;
  assign out_week = o_week_r;
  assign out_weekday = o_dow_r;

`ifndef ASSERT_OFF
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled while the pipeline can still drain");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_week_year != out_year) |->
      (out_week_year == out_year - 1 && out_day_of_year <= 9'd3) ||
      (out_week_year == out_year + 1 && out_day_of_year >= 9'd363))
    else $error("week-year differs from year away from a year boundary");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (out_quarter == 3'd1 && out_month >= 4'd1 && out_month <= 4'd3) ||
      (out_quarter == 3'd2 && out_month >= 4'd4 && out_month <= 4'd6) ||
      (out_quarter == 3'd3 && out_month >= 4'd7 && out_month <= 4'd9) ||
      (out_quarter == 3'd4 && out_month >= 4'd10 && out_month <= 4'd12))
    else $error("quarter does not match month");
`endif

endmodule

### rtl/dnc_cdiv.sv
// Three-stage pipelined divider by a constant using a reciprocal multiply and one correction.
module dnc_cdiv #(
  parameter int W = 31,
  parameter int D = 146097,
  parameter int S = 48,
  parameter int QW = 13,
  parameter int SW = 3,
  localparam int RW = $clog2(D)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [W-1:0]  in_num,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [QW-1:0] out_quot,
  output logic [RW-1:0] out_rem,
  output logic [SW-1:0] out_side
);

  localparam int DW = $clog2(D + 1);
  localparam int MW = S - DW + 1;
  localparam logic [MW-1:0] MUL = MW'((64'd1 << S) / 64'(D));

  logic          v1_r, v2_r, v3_r;
  logic          rdy1, rdy2, rdy3;
  logic [QW-1:0] q1_r, q2_r, q3_r;
  logic [W-1:0]  a1_r;
  logic [RW:0]   rr2_r;
  logic [RW-1:0] r3_r;
  logic [SW-1:0] s1_r, s2_r, s3_r;

  logic [W+MW-1:0]  prod_nxt;
  logic [QW-1:0]    q1_nxt;
  logic [QW+DW-1:0] t_nxt;
  logic [RW:0]      rr2_nxt;
  logic             fix;
  logic [QW-1:0]    q3_nxt;
  logic [RW-1:0]    r3_nxt;

  assign rdy3 = !v3_r || out_ready;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_ready = rdy1;

  assign prod_nxt = (W + MW)'(in_num) * (W + MW)'(MUL);
  assign q1_nxt = prod_nxt[S +: QW];

  assign t_nxt = (QW + DW)'(q1_r) * (QW + DW)'(D);
  assign rr2_nxt = a1_r[RW:0] - t_nxt[RW:0];

  assign fix = rr2_r >= (RW + 1)'(D);
  assign q3_nxt = fix ? q2_r + QW'(1) : q2_r;
  assign r3_nxt = RW'(fix ? rr2_r - (RW + 1)'(D) : rr2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      q1_r <= q1_nxt;
      a1_r <= in_num;
      s1_r <= in_side;
    end
    if (rdy2) begin
      q2_r <= q1_r;
      rr2_r <= rr2_nxt;
      s2_r <= s1_r;
    end
    if (rdy3) begin
      q3_r <= q3_nxt;
      r3_r <= r3_nxt;
      s3_r <= s2_r;
    end
  end

  assign out_valid = v3_r;
  assign out_quot = q3_r;
  assign out_rem = r3_r;
  assign out_side = s3_r;

endmodule
